### hw/rtl/psfd_pkg.sv
package psfd_pkg;

  // Frame geometry of the sensor response.
  localparam int FRAME_LEN = 10;
  localparam int WIN_DEPTH = FRAME_LEN - 1;

  // Byte positions inside one frame.
  localparam int POS_HEADER  = 0;
  localparam int POS_CMD     = 1;
  localparam int POS_PM25_LO = 2;
  localparam int POS_PM25_HI = 3;
  localparam int POS_PM10_LO = 4;
  localparam int POS_PM10_HI = 5;
  localparam int POS_ID_LO   = 6;
  localparam int POS_ID_HI   = 7;
  localparam int POS_CHK     = 8;
  localparam int POS_TAIL    = FRAME_LEN - 1;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COMMAND = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL    = 2'd2;

  localparam logic [7:0] HEADER_RST  = 8'd170;
  localparam logic [7:0] COMMAND_RST = 8'd192;
  localparam logic [7:0] TAIL_RST    = 8'd171;

  // Result field widths.
  localparam int READING_W = 13;
  localparam int DEVICE_W  = 16;

  // Division by ten of a 16-bit value: (x * 52429) >> 19 is exact for every x below 2^16.
  localparam int          DIV10_SHIFT = 19;
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int          PROD_W      = 33;

  typedef logic [7:0] byte_t;
  typedef byte_t [FRAME_LEN-1:0] frame_t;

  typedef struct packed {
    byte_t header;
    byte_t command;
    byte_t tail;
  } cfg_t;

  typedef struct packed {
    logic                 frame_status;
    logic [READING_W-1:0] fine_particles;
    logic [READING_W-1:0] coarse_particles;
    logic [DEVICE_W-1:0]  device_number;
  } result_t;

endpackage

### hw/rtl/psfd_cell.sv
module psfd_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift_en,
  input  psfd_pkg::byte_t      d_byte,
  input  logic                 d_valid,
  output psfd_pkg::byte_t      q_byte,
  output logic                 q_valid
);
  import psfd_pkg::*;

  byte_t byte_r;
  logic  valid_r;

  // The held word only changes when a new word enters the window.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= d_byte;
    end
  end

  // Occupancy flag travels down the row with the word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= d_valid;
    end
  end

  assign q_byte  = byte_r;
  assign q_valid = valid_r;

endmodule

### hw/rtl/psfd_decode.sv
module psfd_decode (
  input  psfd_pkg::frame_t   frame,
  input  psfd_pkg::cfg_t     cfg,
  output logic               match,
  output psfd_pkg::result_t  result
);
  import psfd_pkg::*;

  logic [15:0]       pm25_raw;
  logic [15:0]       pm10_raw;
  logic [PROD_W-1:0] pm25_prod;
  logic [PROD_W-1:0] pm10_prod;
  byte_t             chk_sum;

  // Header, command and tail must all agree with the programmed values.
  assign match = (frame[POS_HEADER] == cfg.header) &&
                 (frame[POS_CMD] == cfg.command) &&
                 (frame[POS_TAIL] == cfg.tail);

  // Checksum is the low byte of the six data words added together.
  assign chk_sum = frame[POS_PM25_LO] + frame[POS_PM25_HI] + frame[POS_PM10_LO] +
                   frame[POS_PM10_HI] + frame[POS_ID_LO] + frame[POS_ID_HI];

  // Readings divided by ten through a reciprocal multiply.
  assign pm25_raw  = {frame[POS_PM25_HI], frame[POS_PM25_LO]};
  assign pm10_raw  = {frame[POS_PM10_HI], frame[POS_PM10_LO]};
  assign pm25_prod = PROD_W'(pm25_raw) * PROD_W'(DIV10_MUL);
  assign pm10_prod = PROD_W'(pm10_raw) * PROD_W'(DIV10_MUL);

  assign result.frame_status     = (chk_sum != frame[POS_CHK]);
  assign result.fine_particles   = pm25_prod[DIV10_SHIFT +: READING_W];
  assign result.coarse_particles = pm10_prod[DIV10_SHIFT +: READING_W];
  assign result.device_number    = {frame[POS_ID_HI], frame[POS_ID_LO]};

endmodule

### hw/rtl/psfd_out_buf.sv
module psfd_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  psfd_pkg::result_t  push_data,
  output logic               has_room,
  output logic               out_valid,
  input  logic               out_ready,
  output psfd_pkg::result_t  out_data
);
  import psfd_pkg::*;

  result_t out_r;
  result_t out_nxt;
  result_t skid_r;
  result_t skid_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    skid_valid_r;
  logic    skid_valid_nxt;

  // Two-entry queue: the output register and a skid entry behind it.
  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_valid_r && !out_ready) begin
      if (push) begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (skid_valid_r) begin
      out_nxt        = skid_r;
      out_valid_nxt  = 1'b1;
      skid_nxt       = push_data;
      skid_valid_nxt = push;
    end else begin
      out_nxt       = push_data;
      out_valid_nxt = push;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  assign has_room  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // No new result may arrive while both entries are occupied.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("result pushed into a full queue");

  // A stalled result is never dropped.
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("stalled result lost");
`endif

endmodule

### hw/rtl/particle_sensor_frame_decoder.sv
// A matching frame's result enters the result queue registers when its tail word is taken.
// Throughput: one received word per cycle; the decode sits behind a row of nine word cells.
// The input stalls only when both entries of the two-deep result queue are occupied.
// Reset (rst_n, synchronous, active low) empties the window and the result queue and
// loads the header, command and tail registers with 170, 192 and 171.
module particle_sensor_frame_decoder (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [7:0]                              in_rx_byte,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_frame_status,
  output logic [psfd_pkg::READING_W-1:0]          out_fine_particles,
  output logic [psfd_pkg::READING_W-1:0]          out_coarse_particles,
  output logic [psfd_pkg::DEVICE_W-1:0]           out_device_number,
  input  logic                                    cfg_we,
  input  logic [psfd_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [psfd_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import psfd_pkg::*;

  cfg_t    cfg_r;
  cfg_t    cfg_nxt;
  byte_t   win_byte  [WIN_DEPTH];
  logic    win_valid [WIN_DEPTH];
  byte_t   chain_byte [WIN_DEPTH];
  logic    chain_valid [WIN_DEPTH];
  frame_t  frame;
  logic    in_accept;
  logic    match;
  logic    push;
  result_t result;
  result_t out_data;

  // Configuration writes; an index past the last register is ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_HEADER:  cfg_nxt.header  = cfg_wdata;
        REG_COMMAND: cfg_nxt.command = cfg_wdata;
        REG_TAIL:    cfg_nxt.tail    = cfg_wdata;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header  <= HEADER_RST;
      cfg_r.command <= COMMAND_RST;
      cfg_r.tail    <= TAIL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_accept = in_valid && in_ready;

  // Row of word cells: the newest word enters at the last cell and moves towards cell zero.
  genvar k;
  generate
    for (k = 0; k < WIN_DEPTH; k++) begin : g_cell
      if (k == WIN_DEPTH - 1) begin : g_last
        assign chain_byte[k]  = in_rx_byte;
        assign chain_valid[k] = 1'b1;
      end else begin : g_mid
        assign chain_byte[k]  = win_byte[k+1];
        assign chain_valid[k] = win_valid[k+1];
      end

      psfd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (in_accept),
        .d_byte   (chain_byte[k]),
        .d_valid  (chain_valid[k]),
        .q_byte   (win_byte[k]),
        .q_valid  (win_valid[k])
      );

      assign frame[k] = win_byte[k];
    end
  endgenerate

  // The incoming word completes the candidate frame.
  assign frame[POS_TAIL] = in_rx_byte;

  psfd_decode u_decode (
    .frame  (frame),
    .cfg    (cfg_r),
    .match  (match),
    .result (result)
  );

  // A frame is only judged once the oldest cell holds a received word.
  assign push = in_accept && win_valid[0] && match;

  psfd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (result),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_frame_status     = out_data.frame_status;
  assign out_fine_particles   = out_data.fine_particles;
  assign out_coarse_particles = out_data.coarse_particles;
  assign out_device_number    = out_data.device_number;

endmodule
